[design/pbf_pkg.sv]
package pbf_pkg;

  localparam int MaxChannels = 16;

  typedef enum logic [2:0] {
    REG_WIDTH    = 3'd0,
    REG_UNSIGNED = 3'd1,
    REG_BIG      = 3'd2,
    REG_FLOAT    = 3'd3,
    REG_CHANNELS = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    WIDTH_16 = 2'd0,
    WIDTH_24 = 2'd1,
    WIDTH_8  = 2'd2,
    WIDTH_32 = 2'd3
  } width_code_t;

  // Conversion settings handed to the converter stage.
  typedef struct packed {
    logic [1:0] width_code;
    logic       unsigned_samples;
    logic       big_endian;
    logic       float_samples;
  } conv_cfg_t;

endpackage

[design/pbf_conv.sv]
// Gathered sample in, IEEE single bits out (combinational).
module pbf_conv (
  input  logic              [31:0] raw,
  input  pbf_pkg::conv_cfg_t       cfg,
  output logic              [31:0] result
);

  logic [31:0] masked;
  logic [31:0] ordered;
  logic [32:0] val;
  logic        neg;
  logic [31:0] mag;
  logic [4:0]  msb;
  logic [31:0] norm;
  logic [23:0] mant;
  logic        rnd;
  logic [24:0] mant_r;
  logic [7:0]  expo;
  logic [7:0]  bias;
  logic        sticky;

  always_comb begin
    masked  = raw;
    ordered = raw;
    bias    = 8'd15;
    if (cfg.float_samples) begin
      ordered = cfg.big_endian ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;
      val     = {1'b0, ordered};
    end else begin
      unique case (pbf_pkg::width_code_t'(cfg.width_code))
        pbf_pkg::WIDTH_8: begin
          masked  = {24'd0, raw[7:0]};
          ordered = masked;
          val = cfg.unsigned_samples ? {25'd0, ordered[7:0]} - 33'd128
                                     : {{25{ordered[7]}}, ordered[7:0]};
          bias = 8'd7;
        end
        pbf_pkg::WIDTH_16: begin
          masked  = {16'd0, raw[15:0]};
          ordered = cfg.big_endian ? {16'd0, masked[7:0], masked[15:8]} : masked;
          val = cfg.unsigned_samples ? {17'd0, ordered[15:0]} - 33'd32768
                                     : {{17{ordered[15]}}, ordered[15:0]};
          bias = 8'd15;
        end
        pbf_pkg::WIDTH_24: begin
          masked  = {8'd0, raw[23:0]};
          ordered = cfg.big_endian ? {8'd0, masked[7:0], masked[15:8], masked[23:16]}
                                   : masked;
          val = cfg.unsigned_samples ? {9'd0, ordered[23:0]} - 33'd8388608
                                     : {{9{ordered[23]}}, ordered[23:0]};
          bias = 8'd23;
        end
        default: begin
          ordered = cfg.big_endian ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;
          val = cfg.unsigned_samples ? {1'b0, ordered} - 33'h080000000
                                     : {ordered[31], ordered};
          bias = 8'd31;
        end
      endcase
    end
  end

  // Magnitude fits 32 bits since |v| <= 2^31.
  always_comb begin
    neg = val[32];
    mag = neg ? 32'(-val) : val[31:0];
    msb = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) msb = 5'(i);
    end
    norm   = mag << (5'd31 - msb);
    mant   = norm[31:8];
    sticky = |norm[6:0];
    rnd    = norm[7] & (sticky | mant[0]);
    mant_r = {1'b0, mant} + {24'd0, rnd};
    expo   = 8'd127 + {3'd0, msb} - bias + {7'd0, mant_r[24]};
    if (cfg.float_samples) begin
      result = ordered;
    end else if (mag == 32'd0) begin
      result = 32'd0;
    end else begin
      result = {neg, expo, mant_r[24] ? mant_r[23:1] : mant_r[22:0]};
    end
  end

endmodule

[design/pcm_bytes_to_float_samples_top.sv]
// Channel | signals                          | direction
// in      | valid, stall, data_byte          | byte stream into block
// out     | out_valid, out_stall, sample_bits, channel, last_of_frame | results
// cfg     | cfg_we, cfg_index, cfg_data      | register writes
//
// One byte taken per cycle unless stalled; a result registers as its last byte
// is taken. The gather stage is one register; conversion is one combinational
// pass into the output register. in stall is high only while the output
// register holds an untaken result and a new one is about to complete.
// Reset (rst, synchronous) clears gather state and registers to defaults.
module pcm_bytes_to_float_samples_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] sample_bits,
  output logic [3:0]  channel,
  output logic        last_of_frame,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  logic [1:0] width_code;
  logic       unsigned_samples;
  logic       big_endian;
  logic       float_samples;
  logic [4:0] channel_count;

  logic [31:0] byte_gather;
  logic [1:0]  byte_count;
  logic [3:0]  channel_index;

  logic [2:0]  size_m1;
  logic        completes;
  logic        take;
  logic        out_free;
  logic [31:0] gathered;
  logic [31:0] conv_bits;
  logic [4:0]  eff;
  logic        last;
  pbf_pkg::conv_cfg_t cfg;

  always_comb begin
    if (float_samples) begin
      size_m1 = 3'd3;
    end else begin
      unique case (pbf_pkg::width_code_t'(width_code))
        pbf_pkg::WIDTH_16: size_m1 = 3'd1;
        pbf_pkg::WIDTH_24: size_m1 = 3'd2;
        pbf_pkg::WIDTH_8:  size_m1 = 3'd0;
        default:           size_m1 = 3'd3;
      endcase
    end
    completes = ({1'b0, byte_count} >= size_m1);
    out_free  = !out_valid || !out_stall;
    stall     = completes && !out_free;
    take      = valid && !stall;
    gathered  = byte_gather | ({24'd0, data_byte} << {byte_count, 3'b000});
    cfg       = '{width_code, unsigned_samples, big_endian, float_samples};
    eff = (channel_count == 5'd0) ? 5'd1 : channel_count;
    if (eff > 5'(pbf_pkg::MaxChannels)) eff = 5'(pbf_pkg::MaxChannels);
    last = ({1'b0, channel_index} + 5'd1) >= eff;
  end

  pbf_conv u_conv (
    .raw    (gathered),
    .cfg    (cfg),
    .result (conv_bits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      width_code       <= 2'd0;
      unsigned_samples <= 1'b0;
      big_endian       <= 1'b0;
      float_samples    <= 1'b0;
      channel_count    <= 5'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pbf_pkg::REG_WIDTH:    width_code       <= cfg_data[1:0];
        pbf_pkg::REG_UNSIGNED: unsigned_samples <= cfg_data[0];
        pbf_pkg::REG_BIG:      big_endian       <= cfg_data[0];
        pbf_pkg::REG_FLOAT:    float_samples    <= cfg_data[0];
        pbf_pkg::REG_CHANNELS: channel_count    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_gather   <= 32'd0;
      byte_count    <= 2'd0;
      channel_index <= 4'd0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (take) begin
        if (completes) begin
          byte_gather   <= 32'd0;
          byte_count    <= 2'd0;
          channel_index <= last ? 4'd0 : channel_index + 4'd1;
          out_valid     <= 1'b1;
        end else begin
          byte_gather <= gathered;
          byte_count  <= byte_count + 2'd1;
        end
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (take && completes) begin
      sample_bits   <= conv_bits;
      channel       <= channel_index;
      last_of_frame <= last;
    end
  end

  // A completed sample never overwrites an untaken result.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !(take && completes))
    else $error("result overwritten");

  // Partial bytes never produce a result.
  a_partial_quiet: assert property (@(posedge clk) disable iff (rst)
    (take && !completes && !(out_valid && !out_stall)) |=> ($stable(out_valid)))
    else $error("spurious result");

  // Only the last channel of a frame wraps the index back to zero.
  a_chan_range: assert property (@(posedge clk) disable iff (rst)
    (take && completes && !last) |=> (channel_index != 4'd0))
    else $error("channel range");

endmodule

[verif/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Register indexes past the last defined register; writes there do nothing.
  localparam logic [2:0] RegSpareFirst = 3'd5;
  localparam logic [2:0] RegSpareLast  = 3'd7;

  typedef struct {
    logic [31:0] bits;
    logic [3:0]  chan;
    logic        last;
  } sample_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        valid = 1'b0;
  logic        stall;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] sample_bits;
  logic [3:0]  channel;
  logic        last_of_frame;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [4:0]  cfg_data = '0;

  pcm_bytes_to_float_samples_top dut (.*);

  always #2 clk = ~clk;

  // Stream bytes waiting to be sent, and converted samples still owed by the block.
  logic [7:0] pending_bytes[$];
  sample_t    expected_samples[$];

  // Shadow of the block's settings and gather state.
  logic [1:0]  sh_width;
  logic        sh_unsigned, sh_big, sh_float;
  logic [4:0]  sh_chan_count;
  logic [31:0] gather;
  logic [1:0]  gathered;
  logic [3:0]  next_chan;

  int  fail_count = 0;
  int  sent_count = 0;
  bit  calm = 1'b0;     // no idling in the final stretch
  bit  held = 1'b0;     // current transaction was stalled, keep it up
  int  in_gap = 0, out_gap = 0;

  // Scale v by 2^-(nbits-1) into single precision, round to nearest even.
  function automatic logic [31:0] to_single(longint v, int nbits);
    logic              sgn;
    longint unsigned   m, mant, rem, half;
    int                p, sh;
    if (v == 0) return 32'h0;
    sgn = v < 0;
    m = sgn ? -v : v;
    p = 0;
    while (p < 40 && (m >> (p + 1)) != 0) p++;
    if (p <= 23) begin
      mant = m << (23 - p);
    end else begin
      sh = p - 23;
      rem = m & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      mant = m >> sh;
      if (rem > half || (rem == half && mant[0])) mant++;
      if (mant == (64'd1 << 24)) begin
        mant >>= 1;
        p++;
      end
    end
    return {sgn, 8'(127 + p - (nbits - 1)), mant[22:0]};
  endfunction

  function automatic int bytes_per_sample();
    if (sh_float) return 4;
    case (pbf_pkg::width_code_t'(sh_width))
      pbf_pkg::WIDTH_16: return 2;
      pbf_pkg::WIDTH_24: return 3;
      pbf_pkg::WIDTH_8:  return 1;
      default:           return 4;
    endcase
  endfunction

  // Fold one accepted byte into the shadow state; queue a sample when it completes.
  task automatic convert_byte(logic [7:0] b);
    int          n, nbits, eff;
    logic [31:0] raw, swapped;
    longint      v;
    sample_t     s;
    n = bytes_per_sample();
    gather |= 32'(b) << (8 * gathered);
    if (int'(gathered) + 1 < n) begin
      gathered++;
      return;
    end
    raw = gather;
    if (n < 4) raw &= (32'd1 << (8 * n)) - 1;
    if (sh_big) begin
      swapped = '0;
      for (int k = 0; k < n; k++) swapped[8*(n-1-k) +: 8] = raw[8*k +: 8];
      raw = swapped;
    end
    gather = '0;
    gathered = '0;
    nbits = 8 * n;
    if (sh_float) begin
      s.bits = raw;
    end else begin
      if (sh_unsigned) v = longint'(raw) - (longint'(1) << (nbits - 1));
      else begin
        v = longint'(raw);
        if (raw[nbits-1]) v -= longint'(1) << nbits;
      end
      s.bits = to_single(v, nbits);
    end
    eff = sh_chan_count == 0 ? 1
        : (sh_chan_count > pbf_pkg::MaxChannels ? pbf_pkg::MaxChannels : sh_chan_count);
    s.chan = next_chan;
    s.last = int'(next_chan) + 1 >= eff;
    next_chan = s.last ? 4'd0 : next_chan + 4'd1;
    expected_samples.push_back(s);
  endtask

  // Rising edge: accept transactions, track register writes, check results.
  always @(posedge clk) begin
    sample_t e;
    if (rst) begin
      sh_width <= pbf_pkg::WIDTH_16; sh_unsigned <= 0; sh_big <= 0; sh_float <= 0;
      sh_chan_count <= 5'd2; gather <= '0; gathered <= '0; next_chan <= '0;
      held <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pbf_pkg::REG_WIDTH:    sh_width = cfg_data[1:0];
          pbf_pkg::REG_UNSIGNED: sh_unsigned = cfg_data[0];
          pbf_pkg::REG_BIG:      sh_big = cfg_data[0];
          pbf_pkg::REG_FLOAT:    sh_float = cfg_data[0];
          pbf_pkg::REG_CHANNELS: sh_chan_count = cfg_data;
          default: ;
        endcase
      end
      held <= valid && stall;
      if (valid && !stall) begin
        convert_byte(data_byte);
        void'(pending_bytes.pop_front());
      end
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected sample bits=%h channel=%0d last=%0b",
                 sample_bits, channel, last_of_frame);
          fail_count++;
        end else begin
          e = expected_samples.pop_front();
          if (sample_bits !== e.bits) begin
            $error("sample_bits expected %h actual %h", e.bits, sample_bits);
            fail_count++;
          end
          if (channel !== e.chan) begin
            $error("channel expected %0d actual %0d", e.chan, channel);
            fail_count++;
          end
          if (last_of_frame !== e.last) begin
            $error("last_of_frame expected %0b actual %0b", e.last, last_of_frame);
            fail_count++;
          end
        end
      end
    end
  end

  // Byte driver: random gaps, but a stalled transaction is held as is.
  always @(negedge clk) begin
    if (rst || held) begin
    end else if (in_gap > 0) begin
      in_gap--;
      valid <= 1'b0;
    end else if (pending_bytes.size() != 0) begin
      if (!calm && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, 6);
        valid <= 1'b0;
      end else begin
        valid <= 1'b1;
        data_byte <= pending_bytes[0];
      end
    end else begin
      valid <= 1'b0;
    end
  end

  // Result side back-pressure in bursts.
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_gap = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [4:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender drained, every sample back, then a settling wait for the output stage.
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || valid) @(negedge clk);
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic send(logic [7:0] b);
    pending_bytes.push_back(b);
    sent_count++;
  endtask

  task automatic setup(logic [1:0] w, bit u, bit bg, bit f, logic [4:0] cc);
    wait_drained();
    write_reg(pbf_pkg::REG_WIDTH, 5'(w));
    write_reg(pbf_pkg::REG_UNSIGNED, 5'(u));
    write_reg(pbf_pkg::REG_BIG, 5'(bg));
    write_reg(pbf_pkg::REG_FLOAT, 5'(f));
    write_reg(pbf_pkg::REG_CHANNELS, cc);
  endtask

  initial begin
    int nbytes;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Defaults: 16-bit signed little-endian stereo; zero and both extremes.
    send(8'h00); send(8'h00);
    send(8'hff); send(8'h7f);
    send(8'h00); send(8'h80);
    // 8-bit unsigned mono: midpoint is zero, ends of range.
    setup(pbf_pkg::WIDTH_8, 1, 0, 0, 5'd1);
    send(8'h80); send(8'h00); send(8'hff); send(8'h7f);
    // 32-bit signed big-endian: rounding at full scale.
    setup(pbf_pkg::WIDTH_32, 0, 1, 0, 5'd3);
    send(8'h7f); send(8'hff); send(8'hff); send(8'hff);
    send(8'h80); send(8'h00); send(8'h00); send(8'h00);
    // Float pass-through, NaN, byte swapped; width and sign settings ignored.
    setup(pbf_pkg::WIDTH_8, 1, 1, 1, 5'd0);
    send(8'h7f); send(8'hc0); send(8'h00); send(8'h01);
    // Size lowered in the middle of a sample.
    setup(pbf_pkg::WIDTH_32, 0, 0, 0, 5'd31);
    send(8'h12); send(8'h34); send(8'h56);
    setup(pbf_pkg::WIDTH_16, 0, 0, 0, 5'd31);
    send(8'h9a);
    // Channel count lowered in the middle of a frame; spare indexes do nothing.
    setup(pbf_pkg::WIDTH_24, 1, 0, 0, 5'd5);
    for (int k = 0; k < 9; k++) send(8'($urandom));
    wait_drained();
    for (logic [2:0] i = RegSpareFirst; i <= RegSpareLast && i != 0; i++)
      write_reg(i, 5'($urandom));
    write_reg(pbf_pkg::REG_CHANNELS, 5'd2);
    for (int k = 0; k < 3; k++) send(8'($urandom));

    // Random phases: mostly whole frames, some ragged ends left mid-sample.
    while (sent_count < 1850) begin
      if (sent_count > 1650) calm = 1'b1;
      setup(2'($urandom), 1'($urandom), 1'($urandom), $urandom_range(0, 4) == 0,
            $urandom_range(0, 7) == 0 ? 5'($urandom) : 5'($urandom_range(1, 16)));
      nbytes = bytes_per_sample() * (sh_chan_count == 0 ? 1 : sh_chan_count)
               * $urandom_range(1, 4);
      if (nbytes > 120) nbytes = 120;
      if ($urandom_range(0, 3) == 0) nbytes += $urandom_range(1, 3);
      for (int k = 0; k < nbytes; k++) send(8'($urandom));
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (fail_count == 0) $display("pcm_bytes_to_float_samples_top verification clean");
    else $display("pcm_bytes_to_float_samples_top verification failed");
    $finish;
  end

  initial begin
    #4ms;
    $display("pcm_bytes_to_float_samples_top verification failed");
    $finish;
  end

endmodule
